// ===== design/nqa_pkg.sv =====
// ============================================================================
// nqa_pkg
// Shared types, widths and constants of the normal quantile pipeline.
// ============================================================================
package nqa_pkg;

  // Port widths
  localparam int unsigned ProbW   = 33;
  localparam int unsigned QuantW  = 32;
  localparam int unsigned MeanW   = 32;
  localparam int unsigned StdW    = 31;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 32;

  // Internal datapath widths
  localparam int unsigned UW      = 32;  // |1 - 2p|, Q0.32
  localparam int unsigned WW      = 64;  // 1 - x*x, Q0.64
  localparam int unsigned ExpW    = 6;
  localparam int unsigned FracW   = 32;
  localparam int unsigned LogW    = ExpW + FracW;  // log2, Q6.32
  localparam int unsigned DdW     = 39;
  localparam int unsigned LqW     = 38;  // L, Q.32
  localparam int unsigned NumW    = 48;  // L * 1000
  localparam int unsigned NumHalfW = NumW / 2;
  localparam int unsigned BqW     = 41;  // L / a, Q.32
  localparam int unsigned TW      = 40;  // T, signed Q.32
  localparam int unsigned TmW     = 36;  // |T|
  localparam int unsigned T27W    = 31;
  localparam int unsigned SqW     = 2 * T27W;
  localparam int unsigned RadW    = 64;
  localparam int unsigned RootW   = 32;
  localparam int unsigned DenW    = 38;
  localparam int unsigned DivQW   = 62;  // quotient bits of the Q.58 divide
  localparam int unsigned DivFrac = 58;
  localparam int unsigned DivLead = DivQW - DivFrac;
  localparam int unsigned ConstDenW = 8;
  localparam int unsigned MagW    = 35;
  localparam int unsigned SumW    = 37;

  // Arithmetic constants
  localparam logic [31:0]          Ln2Q32     = 32'd2977044472;
  localparam logic signed [TW-1:0] TwoOverPiA = 40'sd18600415662;
  localparam logic [30:0]          Sqrt2Q30   = 31'd1518500250;
  localparam logic [9:0]           ANumer     = 10'd1000;
  localparam logic [ConstDenW-1:0] ADenom     = 8'd147;
  localparam logic [ProbW-1:0]     ProbOne    = 33'h1_0000_0000;
  localparam logic [ProbW-1:0]     ProbHalf   = 33'h0_8000_0000;
  localparam logic [MeanW-1:0]     MeanReset  = 32'd0;
  localparam logic [StdW-1:0]      StdReset   = 31'd65536;
  localparam logic signed [QuantW-1:0] QuantMax = 32'sh7FFF_FFFF;
  localparam logic signed [QuantW-1:0] QuantMin = 32'sh8000_0000;

  // Reciprocal of the divisor 147: ceil(2^56 / 147), exact for any 48-bit dividend
  localparam int unsigned RecipSh  = 56;
  localparam int unsigned RecipW   = 49;
  localparam int unsigned RecipLoW = 25;
  localparam int unsigned RecipHiW = RecipW - RecipLoW;
  localparam int unsigned MidW     = 75;
  localparam int unsigned FullW    = 97;
  localparam logic [RecipW-1:0] RecipA =
    RecipW'(((64'd1 << RecipSh) + 64'(ADenom) - 64'd1) / 64'(ADenom));

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgMean = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgStd  = 2'd1;

  // Stage counts and total latency
  localparam int unsigned LatFront = 2;
  localparam int unsigned LatLog   = 2 + FracW;
  localparam int unsigned LatLq    = 4;
  localparam int unsigned LatConst = 3;
  localparam int unsigned LatT     = 3;
  localparam int unsigned LatSqrt  = RootW;
  localparam int unsigned LatDen   = 1;
  localparam int unsigned LatDiv   = DivQW;
  localparam int unsigned LatSel   = 1;
  localparam int unsigned LatTail  = 3;
  localparam int unsigned Latency  = LatFront + LatLog + LatLq + LatConst + LatT +
                                     LatSqrt + LatDen + LatDiv + LatSel + LatSqrt +
                                     LatTail;

  // Result status
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SAT     = 2'd1,
    ST_INVALID = 2'd2
  } status_e;

  // Input class, decided at entry
  typedef enum logic [2:0] {
    CLS_NORMAL  = 3'd0,
    CLS_INVALID = 3'd1,
    CLS_ZERO    = 3'd2,
    CLS_ONE     = 3'd3,
    CLS_HALF    = 3'd4
  } cls_e;

  typedef struct packed {
    cls_e cls;
    logic below;
  } ctrl_t;

endpackage

// ===== design/nqa_log2.sv =====
// ============================================================================
// nqa_log2
// Pipelined log2 in Q6.32: two normalize stages, then one squaring stage
// per fraction bit.
// ============================================================================
module nqa_log2
  import nqa_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [WW-1:0]    w_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [LogW-1:0]  log_o,
  output logic [SideW-1:0] side_o
);

  // normalize, first half: shifts by 32, 16, 8
  logic [WW-1:0]    n1_x_d, n1_x_q;
  logic [2:0]       n1_sh_d, n1_sh_q;
  logic             n1_valid_q;
  logic [SideW-1:0] n1_side_q;

  always_comb begin
    n1_x_d  = w_i;
    n1_sh_d = '0;
    if (n1_x_d[63:32] == '0) begin
      n1_x_d     = n1_x_d << 32;
      n1_sh_d[2] = 1'b1;
    end
    if (n1_x_d[63:48] == '0) begin
      n1_x_d     = n1_x_d << 16;
      n1_sh_d[1] = 1'b1;
    end
    if (n1_x_d[63:56] == '0) begin
      n1_x_d     = n1_x_d << 8;
      n1_sh_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_valid_q <= 1'b0;
    end else begin
      n1_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    n1_x_q    <= n1_x_d;
    n1_sh_q   <= n1_sh_d;
    n1_side_q <= side_i;
  end

  // normalize, second half: shifts by 4, 2, 1
  logic [WW-1:0] n2_x;
  logic [2:0]    n2_sh;

  always_comb begin
    n2_x  = n1_x_q;
    n2_sh = '0;
    if (n2_x[63:60] == '0) begin
      n2_x     = n2_x << 4;
      n2_sh[2] = 1'b1;
    end
    if (n2_x[63:62] == '0) begin
      n2_x     = n2_x << 2;
      n2_sh[1] = 1'b1;
    end
    if (!n2_x[63]) begin
      n2_x     = n2_x << 1;
      n2_sh[0] = 1'b1;
    end
  end

  // squaring chain; entry 0 holds the normalized mantissa
  logic [31:0]      m_q    [FracW+1];
  logic [FracW-1:0] frac_q [FracW+1];
  logic [ExpW-1:0]  e_q    [FracW+1];
  logic [SideW-1:0] side_q [FracW+1];
  logic             vld_q  [FracW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else begin
      vld_q[0] <= n1_valid_q;
    end
  end

  // exponent is 63 minus the total shift
  always_ff @(posedge clk_i) begin
    m_q[0]    <= n2_x[63:32];
    frac_q[0] <= '0;
    e_q[0]    <= ~{n1_sh_q, n2_sh};
    side_q[0] <= n1_side_q;
  end

  for (genvar k = 0; k < FracW; k++) begin : g_sq
    logic [63:0] prod;
    assign prod = 64'(m_q[k]) * 64'(m_q[k]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    // square at or above 2.0 yields a one bit and renormalizes
    always_ff @(posedge clk_i) begin
      if (prod[63]) begin
        m_q[k+1] <= prod[63:32];
      end else begin
        m_q[k+1] <= prod[62:31];
      end
      frac_q[k+1] <= {frac_q[k][FracW-2:0], prod[63]};
      e_q[k+1]    <= e_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[FracW];
  assign log_o   = {e_q[FracW], frac_q[FracW]};
  assign side_o  = side_q[FracW];

endmodule

// ===== design/nqa_isqrt.sv =====
// ============================================================================
// nqa_isqrt
// Pipelined integer floor square root, one result bit per stage.
// ============================================================================
module nqa_isqrt
  import nqa_pkg::*;
#(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [RadW-1:0]  rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  logic [RadW-1:0]  v_q    [RootW];
  logic [RadW-1:0]  r_q    [RootW];
  logic [SideW-1:0] side_q [RootW];
  logic             vld_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam logic [RadW-1:0] Bit = RadW'(1) << (2 * (RootW - 1 - k));

    logic [RadW-1:0]  v_in, r_in, trial;
    logic [SideW-1:0] side_in;
    logic             vld_in;

    if (k == 0) begin : g_first
      assign v_in    = rad_i;
      assign r_in    = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign v_in    = v_q[k-1];
      assign r_in    = r_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = r_in + Bit;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    // restoring step
    always_ff @(posedge clk_i) begin
      if (v_in >= trial) begin
        v_q[k] <= v_in - trial;
        r_q[k] <= (r_in >> 1) + Bit;
      end else begin
        v_q[k] <= v_in;
        r_q[k] <= r_in >> 1;
      end
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = r_q[RootW-1][RootW-1:0];
  assign side_o  = side_q[RootW-1];

endmodule

// ===== design/nqa_div.sv =====
// ============================================================================
// nqa_div
// Pipelined restoring divider, one quotient bit per stage. The dividend is
// a leading remainder (below the divisor) followed by QW low bits.
// ============================================================================
module nqa_div
  import nqa_pkg::*;
#(
  parameter int unsigned DW    = DenW,
  parameter int unsigned QW    = DivQW,
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [DW-1:0]    rem_i,
  input  logic [QW-1:0]    low_i,
  input  logic [DW-1:0]    den_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [QW-1:0]    quot_o,
  output logic [DW-1:0]    den_o,
  output logic [SideW-1:0] side_o
);

  // sr shifts dividend bits out at the top and quotient bits in at the bottom
  logic [DW-1:0]    rem_q  [QW];
  logic [QW-1:0]    sr_q   [QW];
  logic [DW-1:0]    den_q  [QW];
  logic [SideW-1:0] side_q [QW];
  logic             vld_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW-1:0]    rem_in, den_in;
    logic [QW-1:0]    sr_in;
    logic [SideW-1:0] side_in;
    logic             vld_in;
    logic [DW:0]      trial;
    logic             ge;

    if (k == 0) begin : g_first
      assign rem_in  = rem_i;
      assign sr_in   = low_i;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign sr_in   = sr_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    assign trial = {rem_in, sr_in[QW-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ge) begin
        rem_q[k] <= DW'(trial - {1'b0, den_in});
      end else begin
        rem_q[k] <= DW'(trial);
      end
      sr_q[k]   <= {sr_in[QW-2:0], ge};
      den_q[k]  <= den_in;
      side_q[k] <= side_in;
    end
  end

  assign valid_o = vld_q[QW-1];
  assign quot_o  = sr_q[QW-1];
  assign den_o   = den_q[QW-1];
  assign side_o  = side_q[QW-1];

endmodule

// ===== design/normal_quantile_approx.sv =====
// ============================================================================
// normal_quantile_approx
// Inverse normal CDF, mean + sd * z, by a closed-form inverse erf.
// ============================================================================
// Usage:
//   Input: drive probability_i (unsigned Q1.32) and raise start for one
//   cycle; the transfer happens at a clock edge with start high and busy
//   low. busy is never raised, so one probability can enter every cycle.
//   Output: done_o pulses for one cycle with quantile_o (signed Q16.16)
//   and status_o (0 ok, 1 saturated, 2 invalid). Results come out in
//   input order.
//   Throughput is one item per cycle; latency is set by the bit-per-stage
//   units: 32 squaring stages of the log2, two 32-stage square roots and
//   a 62-stage Q.58 divide; L / a is a three-stage reciprocal multiply.
//   Config: cfg_valid_i / cfg_ready_o write mean (index 0, signed Q16.16)
//   or std dev (index 1, unsigned Q15.16); ready is always high. Write
//   only while no item is in flight.
//   Reset: asynchronous, active low; empties the pipeline and restores
//   mean 0.0 and std dev 1.0.
//   The receiver cannot stall: every result is shown for one cycle only.
// ============================================================================
module normal_quantile_approx
  import nqa_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [ProbW-1:0]         probability_i,
  output logic                     done_o,
  output logic signed [QuantW-1:0] quantile_o,
  output logic [1:0]               status_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgW-1:0]          cfg_data_i
);

  typedef struct packed {
    ctrl_t          ctrl;
    logic [BqW-1:0] bq;
    logic [TmW-1:0] tm;
    logic           tpos;
  } sroot_t;

  typedef struct packed {
    ctrl_t ctrl;
    logic  tpos;
  } sdiv_t;

  localparam int unsigned CtrlW  = $bits(ctrl_t);
  localparam int unsigned SRootW = $bits(sroot_t);
  localparam int unsigned SDivW  = $bits(sdiv_t);

  // ---------------------------------------------------------------- config
  logic signed [MeanW-1:0] mean_q;
  logic [StdW-1:0]         std_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q <= MeanReset;
      std_q  <= StdReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMean: mean_q <= cfg_data_i;
        CfgStd:  std_q  <= cfg_data_i[StdW-1:0];
        default: ;
      endcase
    end
  end

  // ------------------------------------------------- stage 1: classify, |x|
  ctrl_t           s1_ctrl_d, s1_ctrl_q;
  logic [UW-1:0]   s1_u_d, s1_u_q;
  logic            s1_valid_q;
  logic [ProbW-1:0] two_p;

  always_comb begin
    two_p           = {probability_i[31:0], 1'b0};
    s1_ctrl_d.below = !probability_i[32] && !probability_i[31];
    if (probability_i > ProbOne) begin
      s1_ctrl_d.cls = CLS_INVALID;
    end else if (probability_i == '0) begin
      s1_ctrl_d.cls = CLS_ZERO;
    end else if (probability_i == ProbOne) begin
      s1_ctrl_d.cls = CLS_ONE;
    end else if (probability_i == ProbHalf) begin
      s1_ctrl_d.cls = CLS_HALF;
    end else begin
      s1_ctrl_d.cls = CLS_NORMAL;
    end
    if (s1_ctrl_d.below) begin
      s1_u_d = UW'(ProbOne - two_p);
    end else begin
      s1_u_d = UW'(two_p - ProbOne);
    end
  end

  // ---------------------------------------------------- stage 2: 1 - x*x
  ctrl_t         s2_ctrl_q;
  logic [WW-1:0] s2_w_q;
  logic          s2_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_ctrl_q <= s1_ctrl_d;
    s1_u_q    <= s1_u_d;
    s2_ctrl_q <= s1_ctrl_q;
    s2_w_q    <= WW'(0) - WW'(s1_u_q) * WW'(s1_u_q);
  end

  // ---------------------------------------------------------------- log2
  logic              lg_valid;
  logic [LogW-1:0]   lg;
  logic [CtrlW-1:0]  lg_side;

  nqa_log2 #(
    .SideW (CtrlW)
  ) u_log2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid_q),
    .w_i     (s2_w_q),
    .side_i  (s2_ctrl_q),
    .valid_o (lg_valid),
    .log_o   (lg),
    .side_o  (lg_side)
  );

  // ------------------------------------------ L = (64 - log2 W) * ln 2
  logic              l1_valid_q, l2_valid_q, l3_valid_q, l4_valid_q;
  ctrl_t             l1_ctrl_q, l2_ctrl_q, l3_ctrl_q, l4_ctrl_q;
  logic [DdW-1:0]    l1_dd_q;
  logic [63:0]       l2_plo_q;
  logic [DdW-1:0]    l2_phi_q;
  logic [LqW-1:0]    l3_lq_q, l4_lq_q;
  logic [NumW-1:0]   l4_num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_valid_q <= 1'b0;
      l2_valid_q <= 1'b0;
      l3_valid_q <= 1'b0;
      l4_valid_q <= 1'b0;
    end else begin
      l1_valid_q <= lg_valid;
      l2_valid_q <= l1_valid_q;
      l3_valid_q <= l2_valid_q;
      l4_valid_q <= l3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    l1_ctrl_q <= ctrl_t'(lg_side);
    l1_dd_q   <= (DdW'(64) << FracW) - DdW'(lg);
    l2_ctrl_q <= l1_ctrl_q;
    l2_plo_q  <= 64'(l1_dd_q[FracW-1:0]) * 64'(Ln2Q32);
    l2_phi_q  <= DdW'(l1_dd_q[DdW-1:FracW]) * DdW'(Ln2Q32);
    l3_ctrl_q <= l2_ctrl_q;
    l3_lq_q   <= LqW'(l2_phi_q) + LqW'(l2_plo_q[63:32]);
    l4_ctrl_q <= l3_ctrl_q;
    l4_lq_q   <= l3_lq_q;
    l4_num_q  <= NumW'(l3_lq_q) * NumW'(ANumer);
  end

  // ------------------------------- L / a: num / 147 by reciprocal multiply
  // partial products of num * RecipA, then the sum, then the top bits
  logic                 a1_valid_q, a2_valid_q, a3_valid_q;
  ctrl_t                a1_ctrl_q, a2_ctrl_q, a3_ctrl_q;
  logic [LqW-1:0]       a1_lq_q, a2_lq_q, a3_lq_q;
  logic [NumHalfW+RecipLoW-1:0] a1_ll_q, a1_hl_q;
  logic [NumHalfW+RecipHiW-1:0] a1_lh_q, a1_hh_q, a2_hh_q;
  logic [MidW-1:0]      a2_mid_q;
  logic [FullW-1:0]     a_full;
  logic [BqW-1:0]       a3_bq_q;

  assign a_full = (FullW'(a2_hh_q) << (NumHalfW + RecipLoW)) + FullW'(a2_mid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_valid_q <= 1'b0;
      a2_valid_q <= 1'b0;
      a3_valid_q <= 1'b0;
    end else begin
      a1_valid_q <= l4_valid_q;
      a2_valid_q <= a1_valid_q;
      a3_valid_q <= a2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_ctrl_q <= l4_ctrl_q;
    a1_lq_q   <= l4_lq_q;
    a1_ll_q   <= (NumHalfW+RecipLoW)'(l4_num_q[NumHalfW-1:0]) *
                 (NumHalfW+RecipLoW)'(RecipA[RecipLoW-1:0]);
    a1_hl_q   <= (NumHalfW+RecipLoW)'(l4_num_q[NumW-1:NumHalfW]) *
                 (NumHalfW+RecipLoW)'(RecipA[RecipLoW-1:0]);
    a1_lh_q   <= (NumHalfW+RecipHiW)'(l4_num_q[NumHalfW-1:0]) *
                 (NumHalfW+RecipHiW)'(RecipA[RecipW-1:RecipLoW]);
    a1_hh_q   <= (NumHalfW+RecipHiW)'(l4_num_q[NumW-1:NumHalfW]) *
                 (NumHalfW+RecipHiW)'(RecipA[RecipW-1:RecipLoW]);
    a2_ctrl_q <= a1_ctrl_q;
    a2_lq_q   <= a1_lq_q;
    a2_hh_q   <= a1_hh_q;
    a2_mid_q  <= MidW'(a1_ll_q) + (MidW'(a1_hl_q) << NumHalfW) +
                 (MidW'(a1_lh_q) << RecipLoW);
    a3_ctrl_q <= a2_ctrl_q;
    a3_lq_q   <= a2_lq_q;
    a3_bq_q   <= a_full[RecipSh+BqW-1:RecipSh];
  end

  // ------------------------------------- T, |T|^2 and the first radicand
  logic signed [TW-1:0] t1_t;
  logic                 t1_valid_q, t2_valid_q, t3_valid_q;
  ctrl_t                t1_ctrl_q, t2_ctrl_q, t3_ctrl_q;
  logic [BqW-1:0]       t1_bq_q, t2_bq_q, t3_bq_q;
  logic [TmW-1:0]       t1_tm_d, t1_tm_q, t2_tm_q, t3_tm_q;
  logic                 t1_tpos_d, t1_tpos_q, t2_tpos_q, t3_tpos_q;
  logic [SqW-1:0]       t2_sq_q;
  logic [RadW-1:0]      t3_rad_q;

  always_comb begin
    t1_t      = TwoOverPiA - TW'(a3_lq_q >> 1);
    t1_tpos_d = (t1_t > 0);
    if (t1_tpos_d) begin
      t1_tm_d = TmW'(t1_t);
    end else begin
      t1_tm_d = TmW'(-t1_t);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
      t2_valid_q <= 1'b0;
      t3_valid_q <= 1'b0;
    end else begin
      t1_valid_q <= a3_valid_q;
      t2_valid_q <= t1_valid_q;
      t3_valid_q <= t2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    t1_ctrl_q <= a3_ctrl_q;
    t1_bq_q   <= a3_bq_q;
    t1_tm_q   <= t1_tm_d;
    t1_tpos_q <= t1_tpos_d;
    t2_ctrl_q <= t1_ctrl_q;
    t2_bq_q   <= t1_bq_q;
    t2_tm_q   <= t1_tm_q;
    t2_tpos_q <= t1_tpos_q;
    t2_sq_q   <= SqW'(t1_tm_q[TmW-1:5]) * SqW'(t1_tm_q[TmW-1:5]);
    t3_ctrl_q <= t2_ctrl_q;
    t3_bq_q   <= t2_bq_q;
    t3_tm_q   <= t2_tm_q;
    t3_tpos_q <= t2_tpos_q;
    t3_rad_q  <= RadW'(t2_sq_q) + (RadW'(t2_bq_q) << 22);
  end

  // ------------------------------------------------------ R = sqrt(...)
  sroot_t            t3_side;
  logic              r_valid;
  logic [RootW-1:0]  r_root;
  logic [SRootW-1:0] r_side_raw;
  sroot_t            r_side;

  assign t3_side.ctrl = t3_ctrl_q;
  assign t3_side.bq   = t3_bq_q;
  assign t3_side.tm   = t3_tm_q;
  assign t3_side.tpos = t3_tpos_q;
  assign r_side       = sroot_t'(r_side_raw);

  nqa_isqrt #(
    .SideW (SRootW)
  ) u_sqrt_r (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (t3_valid_q),
    .rad_i   (t3_rad_q),
    .side_i  (t3_side),
    .valid_o (r_valid),
    .root_o  (r_root),
    .side_o  (r_side_raw)
  );

  // ------------------------------------------------- divisor R + |T|
  logic           d0_valid_q;
  sdiv_t          d0_side_q;
  logic [BqW-1:0] d0_bq_q;
  logic [DenW-1:0] d0_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d0_valid_q <= 1'b0;
    end else begin
      d0_valid_q <= r_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d0_side_q.ctrl <= r_side.ctrl;
    d0_side_q.tpos <= r_side.tpos;
    d0_bq_q        <= r_side.bq;
    d0_den_q       <= DenW'({r_root, 5'b0}) + DenW'(r_side.tm);
  end

  // ----------------------------------- R - T as B / (R + T), Q.58
  logic              dv_valid;
  logic [DivQW-1:0]  dv_quot;
  logic [DenW-1:0]   dv_den;
  logic [SDivW-1:0]  dv_side_raw;
  sdiv_t             dv_side;

  assign dv_side = sdiv_t'(dv_side_raw);

  nqa_div #(
    .DW    (DenW),
    .QW    (DivQW),
    .SideW (SDivW)
  ) u_div_d (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d0_valid_q),
    .rem_i   (DenW'(d0_bq_q >> DivLead)),
    .low_i   ({d0_bq_q[DivLead-1:0], {DivFrac{1'b0}}}),
    .den_i   (d0_den_q),
    .side_i  (d0_side_q),
    .valid_o (dv_valid),
    .quot_o  (dv_quot),
    .den_o   (dv_den),
    .side_o  (dv_side_raw)
  );

  // ------------------------------------------- pick d, then z = sqrt(d)
  logic            d1_valid_q;
  ctrl_t           d1_ctrl_q;
  logic [RadW-1:0] d1_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_valid_q <= 1'b0;
    end else begin
      d1_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_ctrl_q <= dv_side.ctrl;
    if (dv_side.tpos) begin
      d1_d_q <= RadW'(dv_quot);
    end else begin
      d1_d_q <= RadW'(dv_den) << 26;
    end
  end

  logic             z_valid;
  logic [RootW-1:0] z_root;
  logic [CtrlW-1:0] z_side;

  nqa_isqrt #(
    .SideW (CtrlW)
  ) u_sqrt_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (d1_valid_q),
    .rad_i   (d1_d_q),
    .side_i  (d1_ctrl_q),
    .valid_o (z_valid),
    .root_o  (z_root),
    .side_o  (z_side)
  );

  // -------------------------------------- y = z*sqrt2, m = sd*y rounded
  logic             y_valid_q, m_valid_q;
  ctrl_t            y_ctrl_q, m_ctrl_q;
  logic [31:0]      y_val_q;
  logic [MagW-1:0]  m_mag_q;
  logic [63:0]      y_prod, m_prod;

  assign y_prod = 64'(z_root) * 64'(Sqrt2Q30);
  assign m_prod = 64'(std_q) * 64'(y_val_q) + (64'(1) << 28);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_valid_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      y_valid_q <= z_valid;
      m_valid_q <= y_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    y_ctrl_q <= ctrl_t'(z_side);
    y_val_q  <= y_prod[61:30];
    m_ctrl_q <= y_ctrl_q;
    m_mag_q  <= m_prod[63:29];
  end

  // ----------------------------------------- mean +/- m, clamp, specials
  logic signed [SumW-1:0]   o_sum;
  logic signed [QuantW-1:0] o_q_d, o_q_q;
  status_e                  o_st_d, o_st_q;
  logic                     o_valid_q;

  always_comb begin
    if (m_ctrl_q.below) begin
      o_sum = SumW'(mean_q) - $signed(SumW'(m_mag_q));
    end else begin
      o_sum = SumW'(mean_q) + $signed(SumW'(m_mag_q));
    end
    o_q_d  = '0;
    o_st_d = ST_OK;
    case (m_ctrl_q.cls)
      CLS_INVALID: begin
        o_st_d = ST_INVALID;
      end
      CLS_ZERO: begin
        o_q_d  = QuantMin;
        o_st_d = ST_SAT;
      end
      CLS_ONE: begin
        o_q_d  = QuantMax;
        o_st_d = ST_SAT;
      end
      CLS_HALF: begin
        o_q_d = mean_q;
      end
      default: begin
        if (o_sum > SumW'(QuantMax)) begin
          o_q_d  = QuantMax;
          o_st_d = ST_SAT;
        end else if (o_sum < SumW'(QuantMin)) begin
          o_q_d  = QuantMin;
          o_st_d = ST_SAT;
        end else begin
          o_q_d = QuantW'(o_sum);
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else begin
      o_valid_q <= m_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    o_q_q  <= o_q_d;
    o_st_q <= o_st_d;
  end

  assign done_o     = o_valid_q;
  assign quantile_o = o_q_q;
  assign status_o   = o_st_q;

endmodule

// ===== design/nqa_checker.sv =====
// ============================================================================
// nqa_checker
// Port-level checks of the quantile block: fixed latency and result codes.
// ============================================================================
module nqa_checker
  import nqa_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start,
  input logic                     busy,
  input logic                     done_o,
  input logic signed [QuantW-1:0] quantile_o,
  input logic [1:0]               status_o
);

  // every transfer in is matched by a result on done_o
  a_lat_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result missing after input transfer");

  // no result without a matching transfer in
  a_lat_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, Latency))
    else $error("result without input transfer");

  // saturated results sit on an end of the range
  a_sat_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_SAT) |-> (quantile_o == QuantMax || quantile_o == QuantMin))
    else $error("saturated result not at range end");

  // invalid probability gives zero and no unused code appears
  a_inv_val : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o != ST_INVALID || quantile_o == '0) && status_o != 2'd3)
    else $error("bad invalid-status result");

endmodule

bind normal_quantile_approx nqa_checker u_nqa_checker (.*);
